### rtl/spq_pkg.sv
package spq_pkg;

   localparam int SPQ_CAPACITY = 64;
   localparam int VALUE_W      = 32;
   localparam int OP_W         = 3;
   localparam int POS_W        = 6;
   localparam int STATUS_W     = 2;
   localparam int RANK_W       = 6;
   localparam int OCC_W        = 7;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT       = 3'd0,
      OP_POP          = 3'd1,
      OP_REMOVE_RANK  = 3'd2,
      OP_SEARCH       = 3'd3,
      OP_REMOVE_VALUE = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_MISSING = 2'd3
   } status_type;

   typedef enum logic {
      CTRL_IDLE,
      CTRL_APPLY
   } ctrl_state_type;

   // What every cell does at the apply edge.
   typedef enum logic [1:0] {
      MODE_HOLD,
      MODE_INSERT,
      MODE_SHIFT_POS,
      MODE_SHIFT_VAL
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type             mode;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          pos;
   } cell_cmd_type;

endpackage

### rtl/sorted_priority_queue.sv
// Flow: a request is taken only in IDLE; its result is registered as the
//   controller leaves APPLY. The row of cells latches its compare flags at accept
//   and shifts once at the apply edge, and the apply edge waits while a finished
//   result is still stalled.
// Reset: synchronous, active high; empties the queue and drops any held result.
// Cell payload is not cleared; only live bits are.
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY = SPQ_CAPACITY
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [OP_W-1:0]           req_operation,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [POS_W-1:0]          req_position,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic signed [VALUE_W-1:0] rsp_popped_value,
   output logic [RANK_W-1:0]         rsp_found_rank,
   output logic [OCC_W-1:0]          rsp_occupancy
);

   // Per-cell outputs, each read only by its neighbors and the controller.
   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]       live_vec;
   logic [CAPACITY-1:0]       ge_vec;
   logic [CAPACITY-1:0]       eq_vec;
   logic                      capture;
   cell_cmd_type              cmd;

   // The controller sequences each transaction: it latches the request,
   // reduces the cell flags into a rank and a hit, and broadcasts one command.
   spq_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_popped_value(rsp_popped_value),
      .rsp_found_rank  (rsp_found_rank),
      .rsp_occupancy   (rsp_occupancy),
      .capture         (capture),
      .cmd             (cmd),
      .ge_vec          (ge_vec),
      .eq_vec          (eq_vec),
      .live_vec        (live_vec),
      .head_value      (cell_value[0])
   );

   // Row of cells, rank 0 (largest) first. Inserts push toward higher
   // ranks; removals pull from the right neighbor.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] prev_value, next_value;
      logic                      prev_live, prev_ge, next_live;

      if (i == 0) begin : g_head
         // Head acts as if a live, larger entry sat before it.
         assign prev_value = '0;
         assign prev_live  = 1'b1;
         assign prev_ge    = 1'b1;
      end else begin : g_body
         assign prev_value = cell_value[i-1];
         assign prev_live  = live_vec[i-1];
         assign prev_ge    = ge_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         // Tail pulls in an empty slot on a removal.
         assign next_value = '0;
         assign next_live  = 1'b0;
      end else begin : g_mid
         assign next_value = cell_value[i+1];
         assign next_live  = live_vec[i+1];
      end

      spq_cell #(
         .INDEX(i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .capture   (capture),
         .req_value (req_value),
         .cmd       (cmd),
         .prev_value(prev_value),
         .prev_live (prev_live),
         .prev_ge   (prev_ge),
         .next_value(next_value),
         .next_live (next_live),
         .value     (cell_value[i]),
         .live      (live_vec[i]),
         .ge        (ge_vec[i]),
         .eq        (eq_vec[i])
      );
   end

endmodule

### rtl/spq_cell.sv
module spq_cell
   import spq_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      capture,
   input  logic signed [VALUE_W-1:0] req_value,
   input  cell_cmd_type              cmd,
   input  logic signed [VALUE_W-1:0] prev_value,
   input  logic                      prev_live,
   input  logic                      prev_ge,
   input  logic signed [VALUE_W-1:0] next_value,
   input  logic                      next_live,
   output logic signed [VALUE_W-1:0] value,
   output logic                      live,
   output logic                      ge,
   output logic                      eq
);

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      live_ff, live_in;
   logic                      ge_ff, eq_ff;
   logic                      at_pos;
   logic                      before_match;

   assign at_pos       = (INDEX >= int'(cmd.pos));
   // Entries strictly greater than the search value stay put.
   assign before_match = ge_ff && !eq_ff;

   always_comb begin
      value_in = value_ff;
      live_in  = live_ff;
      case (cmd.mode)
         MODE_INSERT: begin
            if (!ge_ff) begin
               value_in = prev_ge ? cmd.value : prev_value;
               live_in  = prev_live;
            end
         end
         MODE_SHIFT_POS: begin
            if (at_pos) begin
               value_in = next_value;
               live_in  = next_live;
            end
         end
         MODE_SHIFT_VAL: begin
            if (!before_match) begin
               value_in = next_value;
               live_in  = next_live;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (capture) begin
         ge_ff <= live_ff && (value_ff >= req_value);
         eq_ff <= live_ff && (value_ff == req_value);
      end
      if (reset) begin
         live_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
      end
   end

   assign value = value_ff;
   assign live  = live_ff;
   assign ge    = ge_ff;
   assign eq    = eq_ff;

endmodule

### rtl/spq_ctrl.sv
module spq_ctrl
   import spq_pkg::*;
#(
   parameter int CAPACITY = SPQ_CAPACITY
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [OP_W-1:0]           req_operation,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [POS_W-1:0]          req_position,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic signed [VALUE_W-1:0] rsp_popped_value,
   output logic [RANK_W-1:0]         rsp_found_rank,
   output logic [OCC_W-1:0]          rsp_occupancy,
   output logic                      capture,
   output cell_cmd_type              cmd,
   input  logic [CAPACITY-1:0]       ge_vec,
   input  logic [CAPACITY-1:0]       eq_vec,
   input  logic [CAPACITY-1:0]       live_vec,
   input  logic signed [VALUE_W-1:0] head_value
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   ctrl_state_type            state_ff, state_in;
   logic [OP_W-1:0]           op_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [POS_W-1:0]          pos_ff;
   logic [CNT_W-1:0]          count_ff, count_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       status_ff;
   logic signed [VALUE_W-1:0] popped_ff;
   logic [RANK_W-1:0]         rank_ff;
   logic [OCC_W-1:0]          occ_ff;

   logic                      out_free, finish, found, full, empty, pos_bad;
   logic [CAPACITY-1:0]       gt_vec, boundary;
   logic [RANK_W-1:0]         rank_enc;
   status_type                status_calc;
   logic signed [VALUE_W-1:0] popped_calc;
   logic [RANK_W-1:0]         rank_calc;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign finish   = (state_ff == CTRL_APPLY) && out_free;
   assign capture  = req_valid && !req_stall;
   assign req_stall = reset || (state_ff != CTRL_IDLE);

   assign found    = |eq_vec;
   assign gt_vec   = ge_vec & ~eq_vec;
   assign boundary = gt_vec & ~(gt_vec >> 1);
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign pos_bad  = (CMP_W'(pos_ff) >= CMP_W'(count_ff));

   always_comb begin
      rank_enc = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (boundary[i]) begin
            rank_enc = rank_enc | RANK_W'(i + 1);
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      status_calc = STATUS_OK;
      popped_calc = '0;
      rank_calc   = '0;
      cmd.mode    = MODE_HOLD;
      cmd.value   = value_ff;
      cmd.pos     = pos_ff;
      case (state_ff)
         CTRL_IDLE: begin
            if (capture) begin
               state_in = CTRL_APPLY;
            end
         end
         CTRL_APPLY: begin
            case (op_ff)
               OP_INSERT: begin
                  if (full) begin
                     status_calc = STATUS_FULL;
                  end else begin
                     cmd.mode = MODE_INSERT;
                     count_in = count_ff + 1'b1;
                  end
               end
               OP_POP: begin
                  if (empty) begin
                     status_calc = STATUS_EMPTY;
                  end else begin
                     popped_calc = head_value;
                     cmd.mode    = MODE_SHIFT_POS;
                     cmd.pos     = '0;
                     count_in    = count_ff - 1'b1;
                  end
               end
               OP_REMOVE_RANK: begin
                  if (pos_bad) begin
                     status_calc = STATUS_MISSING;
                  end else begin
                     cmd.mode = MODE_SHIFT_POS;
                     count_in = count_ff - 1'b1;
                  end
               end
               OP_SEARCH: begin
                  if (found) begin
                     rank_calc = rank_enc;
                  end else begin
                     status_calc = STATUS_MISSING;
                  end
               end
               OP_REMOVE_VALUE: begin
                  if (found) begin
                     rank_calc = rank_enc;
                     cmd.mode  = MODE_SHIFT_VAL;
                     count_in  = count_ff - 1'b1;
                  end else begin
                     status_calc = STATUS_MISSING;
                  end
               end
               default: begin
               end
            endcase
            if (!out_free) begin
               cmd.mode = MODE_HOLD;
               count_in = count_ff;
            end else begin
               state_in = CTRL_IDLE;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         op_ff    <= req_operation;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
      if (finish) begin
         status_ff <= status_calc;
         popped_ff <= popped_calc;
         rank_ff   <= rank_calc;
         occ_ff    <= OCC_W'(count_in);
      end
      if (reset) begin
         state_ff     <= CTRL_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_found_rank   = rank_ff;
   assign rsp_occupancy    = occ_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("live count above capacity");

   a_live_matches_count : assert property (@(posedge clock) disable iff (reset)
      $countones(live_vec) == int'(count_ff))
      else $error("cell live bits disagree with live count");

   a_live_prefix : assert property (@(posedge clock) disable iff (reset)
      ((live_vec >> 1) & ~live_vec) == '0)
      else $error("live cells are not a contiguous prefix");

   a_finish_shows_result : assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("completed operation did not raise a result");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      !finish |=> $stable(count_ff))
      else $error("live count moved outside an apply edge");

endmodule

### verif/testbench.sv
module testbench;
   import spq_pkg::*;

   // Operation codes the block must ignore.
   localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

   localparam int RANDOM_OPS   = 1925;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 4;

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } queue_op_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] popped_value;
      logic [RANK_W-1:0]         found_rank;
      logic [OCC_W-1:0]          occupancy;
   } queue_outcome_type;

   // Workload shape of one stretch of random traffic.
   typedef enum logic [1:0] {
      MIX_FILL,
      MIX_DRAIN,
      MIX_BALANCED
   } mix_type;

   // Receiver stall behavior; each lasts a random number of cycles.
   typedef enum logic [1:0] {
      PACE_FREE,
      PACE_COIN,
      PACE_HEAVY,
      PACE_EVERY_THIRD
   } pace_type;

   logic                      clock         = 1'b0;
   logic                      reset         = 1'b1;
   logic                      req_valid     = 1'b0;
   logic                      req_stall;
   logic [OP_W-1:0]           req_operation = '0;
   logic signed [VALUE_W-1:0] req_value     = '0;
   logic [POS_W-1:0]          req_position  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall     = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_popped_value;
   logic [RANK_W-1:0]         rsp_found_rank;
   logic [OCC_W-1:0]          rsp_occupancy;

   // Shadow copy of the queue: descending order, rank 0 is the largest.
   logic signed [VALUE_W-1:0] ranked_values [SPQ_CAPACITY];
   int                        live_entries = 0;

   queue_op_type      scheduled_ops [$];
   queue_outcome_type awaited_outcomes [$];
   int                total_ops    = 0;
   int                accepted_ops = 0;
   int                mismatches   = 0;
   int                cycle_count  = 0;
   int                burst_left   = 0;
   int                gap_left     = 0;
   pace_type          pace_mode    = PACE_FREE;
   int                pace_hold    = 0;

   sorted_priority_queue DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_value        (req_value),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .rsp_found_rank   (rsp_found_rank),
      .rsp_occupancy    (rsp_occupancy)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one transaction to the shadow queue and return what the block
   // must answer. Equal values keep arrival order: a new entry lands after
   // every entry that is greater than or equal to it.
   function automatic queue_outcome_type queue_shadow_step(queue_op_type op);
      queue_outcome_type res;
      int                slot;
      int                hit_rank;
      res.status       = STATUS_OK;
      res.popped_value = '0;
      res.found_rank   = '0;
      hit_rank         = -1;
      if (op.operation == OP_SEARCH || op.operation == OP_REMOVE_VALUE) begin
         for (int k = 0; k < live_entries; k++) begin
            if (hit_rank < 0 && ranked_values[k] == op.value) begin
               hit_rank = k;
            end
         end
      end
      case (op.operation)
         OP_INSERT: begin
            if (live_entries >= SPQ_CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               slot = live_entries;
               while (slot > 0 && ranked_values[slot-1] < op.value) begin
                  ranked_values[slot] = ranked_values[slot-1];
                  slot--;
               end
               ranked_values[slot] = op.value;
               live_entries++;
            end
         end
         OP_POP: begin
            if (live_entries == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.popped_value = ranked_values[0];
               hit_rank = 0;
            end
         end
         OP_REMOVE_RANK: begin
            if (int'(op.position) >= live_entries) begin
               res.status = STATUS_MISSING;
            end else begin
               hit_rank = int'(op.position);
            end
         end
         OP_SEARCH, OP_REMOVE_VALUE: begin
            if (hit_rank < 0) begin
               res.status = STATUS_MISSING;
            end else begin
               res.found_rank = hit_rank[RANK_W-1:0];
            end
         end
         default: begin
            // Unused codes leave the queue alone and report success.
         end
      endcase
      // Close the gap left by any removal.
      if (res.status == STATUS_OK && hit_rank >= 0 && op.operation != OP_SEARCH &&
          (op.operation == OP_POP || op.operation == OP_REMOVE_RANK ||
           op.operation == OP_REMOVE_VALUE)) begin
         for (int k = hit_rank; k + 1 < live_entries; k++) begin
            ranked_values[k] = ranked_values[k+1];
         end
         live_entries--;
      end
      res.occupancy = live_entries[OCC_W-1:0];
      return res;
   endfunction

   task automatic schedule_op(logic [OP_W-1:0] operation, logic signed [VALUE_W-1:0] value,
                              logic [POS_W-1:0] position);
      queue_op_type op;
      op.operation = operation;
      op.value     = value;
      op.position  = position;
      scheduled_ops.push_back(op);
      total_ops++;
   endtask

   // Favor a small pool so that duplicates and search hits are common.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         return $signed($urandom_range(0, 12)) - 6;
      end else if (pick == 5) begin
         case ($urandom_range(0, 3))
            0:       return VALUE_MAX;
            1:       return VALUE_MIN;
            2:       return '0;
            default: return -1;
         endcase
      end
      return $signed($urandom());
   endfunction

   function automatic logic [OP_W-1:0] pick_operation(mix_type mix);
      int roll;
      int insert_pct;
      int pop_pct;
      int rank_pct;
      int search_pct;
      int remove_pct;
      case (mix)
         MIX_FILL: begin
            insert_pct = 70; pop_pct = 6;  rank_pct = 6;  search_pct = 8;  remove_pct = 7;
         end
         MIX_DRAIN: begin
            insert_pct = 15; pop_pct = 35; rank_pct = 20; search_pct = 12; remove_pct = 15;
         end
         default: begin
            insert_pct = 35; pop_pct = 20; rank_pct = 15; search_pct = 15; remove_pct = 12;
         end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) return OP_INSERT;
      roll -= insert_pct;
      if (roll < pop_pct) return OP_POP;
      roll -= pop_pct;
      if (roll < rank_pct) return OP_REMOVE_RANK;
      roll -= rank_pct;
      if (roll < search_pct) return OP_SEARCH;
      roll -= search_pct;
      if (roll < remove_pct) return OP_REMOVE_VALUE;
      return OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
   endfunction

   // Build the whole stimulus, release reset, then wait for the queue of
   // awaited outcomes to drain before judging the run.
   initial begin
      int      remaining;
      int      stretch;
      mix_type mix;

      // Directed: empty-queue errors first.
      schedule_op(OP_POP,          '0,    '0);
      schedule_op(OP_REMOVE_RANK,  '0,    '0);
      schedule_op(OP_SEARCH,       5,     '0);
      schedule_op(OP_REMOVE_VALUE, 5,     '0);
      // Extremes and duplicates; duplicates must keep arrival order.
      schedule_op(OP_INSERT,       '0,        '0);
      schedule_op(OP_INSERT,       VALUE_MAX, '0);
      schedule_op(OP_INSERT,       VALUE_MIN, '0);
      schedule_op(OP_INSERT,       '0,        '1);
      schedule_op(OP_INSERT,       -1,        '0);
      schedule_op(OP_INSERT,       VALUE_MAX, '0);
      schedule_op(OP_SEARCH,       '0,        '0);
      schedule_op(OP_SEARCH,       123,       '0);
      // Rank out of range, both far and just past the end, then the last valid rank.
      schedule_op(OP_REMOVE_RANK,  '0,        '1);
      schedule_op(OP_REMOVE_RANK,  '0,        6'd6);
      schedule_op(OP_REMOVE_RANK,  '0,        6'd5);
      schedule_op(OP_REMOVE_VALUE, '0,        '0);
      schedule_op(OP_POP,          '0,        '0);
      for (int code = OP_UNUSED_FIRST; code <= OP_UNUSED_LAST; code++) begin
         schedule_op(code[OP_W-1:0], '1, '1);
      end
      schedule_op(OP_SEARCH,       VALUE_MIN, '0);
      schedule_op(OP_REMOVE_VALUE, VALUE_MAX, '0);
      schedule_op(OP_POP,          '0,        '0);
      schedule_op(OP_POP,          '0,        '0);
      schedule_op(OP_POP,          '0,        '0);

      // Random: alternate stretches that fill to capacity, drain to empty,
      // and hover in between, so full and empty are both hit repeatedly.
      remaining = RANDOM_OPS;
      while (remaining > 0) begin
         mix     = mix_type'($urandom_range(0, 2));
         stretch = $urandom_range(120, 220);
         if (stretch > remaining) stretch = remaining;
         for (int n = 0; n < stretch; n++) begin
            schedule_op(pick_operation(mix), pick_value(),
                        ($urandom_range(0, 1) != 0) ? POS_W'($urandom_range(0, 7)) :
                                                      POS_W'($urandom_range(0, 63)));
         end
         remaining -= stretch;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (accepted_ops != total_ops || awaited_outcomes.size() != 0);
      // Hold for DRAIN_CYCLES so a stray result still gets caught.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // Driver: hold a stalled transaction, otherwise advance to the next one,
   // working in bursts with random gaps between them.
   always @(posedge clock) begin : drive_requests
      queue_op_type next_op;
      if (reset) begin
         req_valid     <= 1'b0;
         req_operation <= '0;
         req_value     <= '0;
         req_position  <= '0;
         burst_left    <= 0;
         gap_left      <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            next_op.operation = req_operation;
            next_op.value     = req_value;
            next_op.position  = req_position;
            awaited_outcomes.push_back(queue_shadow_step(next_op));
            accepted_ops++;
         end
         if (req_valid && req_stall) begin
            // Hold the payload until the block takes it.
         end else if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (scheduled_ops.size() != 0) begin
            next_op        = scheduled_ops.pop_front();
            req_valid     <= 1'b1;
            req_operation <= next_op.operation;
            req_value     <= next_op.value;
            req_position  <= next_op.position;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: switch stall behavior after each randomly drawn hold.
   always @(posedge clock) begin : pace_responses
      if (pace_hold == 0) begin
         pace_mode <= pace_type'($urandom_range(0, 3));
         pace_hold <= $urandom_range(32, 300);
      end else begin
         pace_hold <= pace_hold - 1;
      end
      case (pace_mode)
         PACE_FREE:  rsp_stall <= 1'b0;
         PACE_COIN:  rsp_stall <= ($urandom_range(0, 1) != 0);
         PACE_HEAVY: rsp_stall <= ($urandom_range(0, 4) != 0);
         default:    rsp_stall <= (cycle_count % 3 == 0);
      endcase
   end

   // Monitor: compare every accepted result with the oldest awaited outcome.
   always @(posedge clock) begin : check_responses
      queue_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_outcomes.size() == 0) begin
            $error("result with no transaction outstanding: status %0d occupancy %0d",
                   rsp_status, rsp_occupancy);
            mismatches++;
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_popped_value !== want.popped_value) begin
               $error("popped_value: expected %0d, got %0d",
                      want.popped_value, rsp_popped_value);
               mismatches++;
            end
            if (rsp_found_rank !== want.found_rank) begin
               $error("found_rank: expected %0d, got %0d", want.found_rank, rsp_found_rank);
               mismatches++;
            end
            if (rsp_occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_occupancy);
               mismatches++;
            end
         end
      end
   end

   // Drop the run if it hangs.
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

endmodule
